// File: rtl/core/chip8_instruction_encoder_defines.svh
// ----------------------------------------------------------------------------
// chip8_instruction_encoder_defines.svh
// Assertion macros used by the chip8_instruction_encoder module.
// ----------------------------------------------------------------------------
`ifndef CHIP8_INSTRUCTION_ENCODER_DEFINES_SVH
`define CHIP8_INSTRUCTION_ENCODER_DEFINES_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define C8ENC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, quiet during reset
`define C8ENC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/c8enc_pkg.sv
// ----------------------------------------------------------------------------
// c8enc_pkg
// Mnemonic and operand kind codes, field widths and the format table.
// ----------------------------------------------------------------------------
package c8enc_pkg;

    localparam int MN_W    = 5;
    localparam int CNT_W   = 2;
    localparam int KIND_W  = 4;
    localparam int VAL_W   = 12;
    localparam int OP_W    = 16;
    localparam int SH_W    = 4;
    localparam int NUM_OPS = 3;

    typedef enum logic [MN_W-1:0] {
        MN_CLS  = 5'd0,
        MN_RET  = 5'd1,
        MN_JP   = 5'd2,
        MN_CALL = 5'd3,
        MN_SE   = 5'd4,
        MN_SNE  = 5'd5,
        MN_LD   = 5'd6,
        MN_ADD  = 5'd7,
        MN_OR   = 5'd8,
        MN_AND  = 5'd9,
        MN_SUB  = 5'd10,
        MN_SHR  = 5'd11,
        MN_SUBN = 5'd12,
        MN_SHL  = 5'd13,
        MN_RND  = 5'd14,
        MN_DRW  = 5'd15,
        MN_SKP  = 5'd16,
        MN_SKNP = 5'd17,
        MN_XOR  = 5'd18
    } mnem_t;

    typedef enum logic [KIND_W-1:0] {
        KD_V   = 4'd0,
        KD_N   = 4'd1,
        KD_B   = 4'd2,
        KD_DT  = 4'd3,
        KD_F   = 4'd4,
        KD_I   = 4'd5,
        KD_IP  = 4'd6,
        KD_K   = 4'd7,
        KD_ST  = 4'd8
    } kind_t;

    typedef struct packed {
        mnem_t                       mn;
        logic [OP_W-1:0]             base;
        logic [CNT_W-1:0]            cnt;
        kind_t [0:NUM_OPS-1]         kind;
        logic [0:NUM_OPS-1][OP_W-1:0] mask;
        logic [0:NUM_OPS-1][SH_W-1:0] sh;
    } fmt_row_t;

    localparam int FMT_COUNT = 33;

    localparam logic [OP_W-1:0] M_X   = 16'h0F00;
    localparam logic [OP_W-1:0] M_Y   = 16'h00F0;
    localparam logic [OP_W-1:0] M_KK  = 16'h00FF;
    localparam logic [OP_W-1:0] M_NNN = 16'h0FFF;
    localparam logic [OP_W-1:0] M_N   = 16'h000F;
    localparam logic [OP_W-1:0] M_0   = 16'h0000;

    // first match in table order wins
    localparam fmt_row_t FMT_TABLE [FMT_COUNT] = '{
        '{MN_CLS,  16'h00E0, 2'd0, '{KD_V,  KD_V,  KD_V}, '{M_0, M_0, M_0},   '{4'd0, 4'd0, 4'd0}},
        '{MN_RET,  16'h00EE, 2'd0, '{KD_V,  KD_V,  KD_V}, '{M_0, M_0, M_0},   '{4'd0, 4'd0, 4'd0}},
        '{MN_CALL, 16'h2000, 2'd1, '{KD_N,  KD_V,  KD_V}, '{M_NNN, M_0, M_0}, '{4'd0, 4'd0, 4'd0}},
        '{MN_SE,   16'h3000, 2'd2, '{KD_V,  KD_N,  KD_V}, '{M_X, M_KK, M_0},  '{4'd8, 4'd0, 4'd0}},
        '{MN_SNE,  16'h4000, 2'd2, '{KD_V,  KD_N,  KD_V}, '{M_X, M_KK, M_0},  '{4'd8, 4'd0, 4'd0}},
        '{MN_SE,   16'h5000, 2'd2, '{KD_V,  KD_V,  KD_V}, '{M_X, M_Y, M_0},   '{4'd8, 4'd4, 4'd0}},
        '{MN_LD,   16'h6000, 2'd2, '{KD_V,  KD_N,  KD_V}, '{M_X, M_KK, M_0},  '{4'd8, 4'd0, 4'd0}},
        '{MN_ADD,  16'h7000, 2'd2, '{KD_V,  KD_N,  KD_V}, '{M_X, M_KK, M_0},  '{4'd8, 4'd0, 4'd0}},
        '{MN_LD,   16'h8000, 2'd2, '{KD_V,  KD_V,  KD_V}, '{M_X, M_Y, M_0},   '{4'd8, 4'd4, 4'd0}},
        '{MN_OR,   16'h8001, 2'd2, '{KD_V,  KD_V,  KD_V}, '{M_X, M_Y, M_0},   '{4'd8, 4'd4, 4'd0}},
        '{MN_AND,  16'h8002, 2'd2, '{KD_V,  KD_V,  KD_V}, '{M_X, M_Y, M_0},   '{4'd8, 4'd4, 4'd0}},
        '{MN_XOR,  16'h8003, 2'd2, '{KD_V,  KD_V,  KD_V}, '{M_X, M_Y, M_0},   '{4'd8, 4'd4, 4'd0}},
        '{MN_ADD,  16'h8004, 2'd2, '{KD_V,  KD_V,  KD_V}, '{M_X, M_Y, M_0},   '{4'd8, 4'd4, 4'd0}},
        '{MN_SUB,  16'h8005, 2'd2, '{KD_V,  KD_V,  KD_V}, '{M_X, M_Y, M_0},   '{4'd8, 4'd4, 4'd0}},
        '{MN_SHR,  16'h8006, 2'd1, '{KD_V,  KD_V,  KD_V}, '{M_X, M_0, M_0},   '{4'd8, 4'd0, 4'd0}},
        '{MN_SUBN, 16'h8007, 2'd2, '{KD_V,  KD_V,  KD_V}, '{M_X, M_Y, M_0},   '{4'd8, 4'd4, 4'd0}},
        '{MN_SHL,  16'h800E, 2'd1, '{KD_V,  KD_V,  KD_V}, '{M_X, M_0, M_0},   '{4'd8, 4'd0, 4'd0}},
        '{MN_SNE,  16'h9000, 2'd2, '{KD_V,  KD_V,  KD_V}, '{M_X, M_Y, M_0},   '{4'd8, 4'd4, 4'd0}},
        '{MN_LD,   16'hA000, 2'd2, '{KD_I,  KD_N,  KD_V}, '{M_0, M_NNN, M_0}, '{4'd0, 4'd0, 4'd0}},
        '{MN_JP,   16'hB000, 2'd2, '{KD_V,  KD_N,  KD_V}, '{M_0, M_NNN, M_0}, '{4'd0, 4'd0, 4'd0}},
        '{MN_RND,  16'hC000, 2'd2, '{KD_V,  KD_N,  KD_V}, '{M_X, M_KK, M_0},  '{4'd8, 4'd0, 4'd0}},
        '{MN_DRW,  16'hD000, 2'd3, '{KD_V,  KD_V,  KD_N}, '{M_X, M_Y, M_N},   '{4'd8, 4'd4, 4'd0}},
        '{MN_SKP,  16'hE09E, 2'd1, '{KD_V,  KD_V,  KD_V}, '{M_X, M_0, M_0},   '{4'd8, 4'd0, 4'd0}},
        '{MN_SKNP, 16'hE0A1, 2'd1, '{KD_V,  KD_V,  KD_V}, '{M_X, M_0, M_0},   '{4'd8, 4'd0, 4'd0}},
        '{MN_LD,   16'hF007, 2'd2, '{KD_V,  KD_DT, KD_V}, '{M_X, M_0, M_0},   '{4'd8, 4'd0, 4'd0}},
        '{MN_LD,   16'hF00A, 2'd2, '{KD_V,  KD_K,  KD_V}, '{M_X, M_0, M_0},   '{4'd8, 4'd0, 4'd0}},
        '{MN_LD,   16'hF015, 2'd2, '{KD_DT, KD_V,  KD_V}, '{M_0, M_X, M_0},   '{4'd0, 4'd8, 4'd0}},
        '{MN_LD,   16'hF018, 2'd2, '{KD_ST, KD_V,  KD_V}, '{M_0, M_X, M_0},   '{4'd0, 4'd8, 4'd0}},
        '{MN_ADD,  16'hF01E, 2'd2, '{KD_I,  KD_V,  KD_V}, '{M_0, M_X, M_0},   '{4'd0, 4'd8, 4'd0}},
        '{MN_LD,   16'hF029, 2'd2, '{KD_F,  KD_V,  KD_V}, '{M_0, M_X, M_0},   '{4'd0, 4'd8, 4'd0}},
        '{MN_LD,   16'hF033, 2'd2, '{KD_B,  KD_V,  KD_V}, '{M_0, M_X, M_0},   '{4'd0, 4'd8, 4'd0}},
        '{MN_LD,   16'hF055, 2'd2, '{KD_IP, KD_V,  KD_V}, '{M_0, M_X, M_0},   '{4'd0, 4'd8, 4'd0}},
        '{MN_LD,   16'hF065, 2'd2, '{KD_V,  KD_IP, KD_V}, '{M_X, M_0, M_0},   '{4'd8, 4'd0, 4'd0}}
    };

endpackage

// File: rtl/core/c8enc_match.sv
// ----------------------------------------------------------------------------
// c8enc_match
// Matches one instruction against the format table and packs the opcode.
// ----------------------------------------------------------------------------
module c8enc_match (
    input  logic [c8enc_pkg::MN_W-1:0]   mnemonic,
    input  logic [c8enc_pkg::CNT_W-1:0]  operand_count,
    input  logic [c8enc_pkg::KIND_W-1:0] kind_first,
    input  logic [c8enc_pkg::KIND_W-1:0] kind_second,
    input  logic [c8enc_pkg::KIND_W-1:0] kind_third,
    input  logic [c8enc_pkg::VAL_W-1:0]  value_first,
    input  logic [c8enc_pkg::VAL_W-1:0]  value_second,
    input  logic [c8enc_pkg::VAL_W-1:0]  value_third,
    output logic                         matched,
    output logic [c8enc_pkg::OP_W-1:0]   opcode
);
    import c8enc_pkg::*;

    logic [NUM_OPS-1:0][KIND_W-1:0] kinds;
    logic [NUM_OPS-1:0][VAL_W-1:0]  vals;
    logic [FMT_COUNT-1:0]           hit;
    fmt_row_t                       row_sel;

    assign kinds = {kind_third, kind_second, kind_first};
    assign vals  = {value_third, value_second, value_first};

    // compare every row at once
    always_comb
    begin
        for (int i = 0; i < FMT_COUNT; i++)
        begin
            hit[i] = (FMT_TABLE[i].mn == mnemonic) && (FMT_TABLE[i].cnt == operand_count);
            for (int j = 0; j < NUM_OPS; j++)
            begin
                if ((CNT_W'(j) < operand_count) && (FMT_TABLE[i].kind[j] != kinds[j]))
                begin
                    hit[i] = 1'b0;
                end
            end
        end
    end

    // priority select: the lowest matching row wins
    always_comb
    begin
        row_sel = FMT_TABLE[0];
        for (int i = FMT_COUNT - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                row_sel = FMT_TABLE[i];
            end
        end
    end

    always_comb
    begin
        matched = |hit;
        opcode  = '0;
        if (matched)
        begin
            opcode = row_sel.base;
            for (int j = 0; j < NUM_OPS; j++)
            begin
                if (CNT_W'(j) < operand_count)
                begin
                    opcode = opcode
                           | ((OP_W'(vals[j]) << row_sel.sh[j]) & row_sel.mask[j]);
                end
            end
        end
    end

endmodule

// File: rtl/core/chip8_instruction_encoder.sv
// ----------------------------------------------------------------------------
// chip8_instruction_encoder
// Pipeline: input register, table match, result register. Throughput: one item
// per cycle while out_ready is not held low, set by the single-pass match
// between the two registers. Reset clears both valid flags; the data
// registers are not reset.
// ----------------------------------------------------------------------------
`include "chip8_instruction_encoder_defines.svh"

module chip8_instruction_encoder (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [c8enc_pkg::MN_W-1:0]   mnemonic,
    input  logic [c8enc_pkg::CNT_W-1:0]  operand_count,
    input  logic [c8enc_pkg::KIND_W-1:0] kind_first,
    input  logic [c8enc_pkg::KIND_W-1:0] kind_second,
    input  logic [c8enc_pkg::KIND_W-1:0] kind_third,
    input  logic [c8enc_pkg::VAL_W-1:0]  value_first,
    input  logic [c8enc_pkg::VAL_W-1:0]  value_second,
    input  logic [c8enc_pkg::VAL_W-1:0]  value_third,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         matched,
    output logic [c8enc_pkg::OP_W-1:0]   opcode
);
    import c8enc_pkg::*;

    logic                s1_valid_reg;
    logic                s1_valid_next;
    logic [MN_W-1:0]     mn_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [KIND_W-1:0]   kind_first_reg;
    logic [KIND_W-1:0]   kind_second_reg;
    logic [KIND_W-1:0]   kind_third_reg;
    logic [VAL_W-1:0]    value_first_reg;
    logic [VAL_W-1:0]    value_second_reg;
    logic [VAL_W-1:0]    value_third_reg;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic                matched_reg;
    logic [OP_W-1:0]     opcode_reg;

    logic                out_load;
    logic                match_hit;
    logic [OP_W-1:0]     match_opcode;

    // result register frees when empty or taken this cycle
    assign out_load       = !out_valid_reg || out_ready;
    assign in_ready       = !s1_valid_reg || out_load;
    assign s1_valid_next  = in_ready ? in_valid : s1_valid_reg;
    assign out_valid_next = out_load ? s1_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input register: load on accept
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            mn_reg           <= mnemonic;
            cnt_reg          <= operand_count;
            kind_first_reg   <= kind_first;
            kind_second_reg  <= kind_second;
            kind_third_reg   <= kind_third;
            value_first_reg  <= value_first;
            value_second_reg <= value_second;
            value_third_reg  <= value_third;
        end
    end

    c8enc_match u_match (
        .mnemonic      (mn_reg),
        .operand_count (cnt_reg),
        .kind_first    (kind_first_reg),
        .kind_second   (kind_second_reg),
        .kind_third    (kind_third_reg),
        .value_first   (value_first_reg),
        .value_second  (value_second_reg),
        .value_third   (value_third_reg),
        .matched       (match_hit),
        .opcode        (match_opcode)
    );

    // result register: advance when the stage ahead is free
    always_ff @(posedge clk)
    begin
        if (out_load && s1_valid_reg)
        begin
            matched_reg <= match_hit;
            opcode_reg  <= match_opcode;
        end
    end

    assign out_valid = out_valid_reg;
    assign matched   = matched_reg;
    assign opcode    = opcode_reg;

    `C8ENC_ASSERT_NOW(a_nomatch_zero, out_valid_reg && !matched_reg, opcode_reg == '0, "unmatched item carries a nonzero opcode")
    `C8ENC_ASSERT_NOW(a_match_nonzero, out_valid_reg && matched_reg, opcode_reg != '0, "matched item carries a zero opcode")
    `C8ENC_ASSERT_NEXT(a_accept_lands, in_valid && in_ready, s1_valid_reg, "accepted item lost before the match stage")
    `C8ENC_ASSERT_NEXT(a_stall_holds, s1_valid_reg && !out_load, s1_valid_reg && out_valid_reg, "item dropped while the result stage was stalled")
    `C8ENC_ASSERT_NOW(a_empty_ready, !s1_valid_reg && !out_valid_reg, in_ready, "empty pipeline refuses input")

endmodule

// File: tb/chip8_instruction_encoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// chip8_instruction_encoder_tb
// A directed table first covers every mnemonic, field extremes and the formats
// that must not match. A long random run follows, mostly legal formats with
// random operands plus broken and garbage instructions. Each result is checked
// against a typed expectation or an in-bench format matcher. Both handshakes
// stall at random, and one long output hold-off backs the pipeline up into its input.
// ----------------------------------------------------------------------------
module chip8_instruction_encoder_tb;
    import c8enc_pkg::*;

    localparam int               RANDOM_ITEMS = 1725;
    localparam int               CYCLE_LIMIT  = 200000;
    localparam int               HOLD_AT      = 1200;
    localparam int               HOLD_CYCLES  = 60;
    localparam logic [MN_W-1:0]   MN_BOGUS    = 5'd31;
    localparam logic [KIND_W-1:0] KD_BOGUS    = 4'd15;

    typedef struct packed {
        logic [MN_W-1:0]                    mnemonic;
        logic [CNT_W-1:0]                   count;
        logic [NUM_OPS-1:0][KIND_W-1:0]     kd;
        logic [NUM_OPS-1:0][VAL_W-1:0]      val;
    } instr_t;

    typedef struct packed {
        instr_t          it;
        logic            known;
        logic            hit;
        logic [OP_W-1:0] word;
    } stim_t;

    typedef struct packed {
        logic [MN_W-1:0]                mn;
        logic [OP_W-1:0]                base;
        logic [CNT_W-1:0]               cnt;
        logic [NUM_OPS-1:0][KIND_W-1:0] kd;
        logic [NUM_OPS-1:0][OP_W-1:0]   mk;
        logic [NUM_OPS-1:0][3:0]        sh;
    } fmt_t;

    typedef struct packed {
        logic            hit;
        logic [OP_W-1:0] word;
    } encoding_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    logic             out_valid;
    logic             out_ready;
    logic             matched;
    logic [OP_W-1:0]  opcode;
    stim_t            offer;

    fmt_t             formats[$];
    stim_t            directed[$];
    encoding_t        expected_words[$];
    int               n_accepted = 0;
    int               n_encoded = 0;
    int               n_rejected = 0;
    int               n_errors = 0;
    int               cycles = 0;
    bit               no_idle = 1'b0;

    chip8_instruction_encoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mnemonic      (offer.it.mnemonic),
        .operand_count (offer.it.count),
        .kind_first    (offer.it.kd[0]),
        .kind_second   (offer.it.kd[1]),
        .kind_third    (offer.it.kd[2]),
        .value_first   (offer.it.val[0]),
        .value_second  (offer.it.val[1]),
        .value_third   (offer.it.val[2]),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .matched       (matched),
        .opcode        (opcode)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void add_fmt(input mnem_t mn, input logic [OP_W-1:0] base,
                                    input int cnt, input kind_t k0, input kind_t k1,
                                    input kind_t k2, input logic [OP_W-1:0] m0,
                                    input logic [OP_W-1:0] m1, input logic [OP_W-1:0] m2,
                                    input int s0, input int s1, input int s2);
        fmt_t f;
        f.mn    = mn;
        f.base  = base;
        f.cnt   = cnt[CNT_W-1:0];
        f.kd[0] = k0;
        f.kd[1] = k1;
        f.kd[2] = k2;
        f.mk[0] = m0;
        f.mk[1] = m1;
        f.mk[2] = m2;
        f.sh[0] = s0[3:0];
        f.sh[1] = s1[3:0];
        f.sh[2] = s2[3:0];
        formats.push_back(f);
    endfunction

    function automatic void add_row(input logic [MN_W-1:0] mn, input int cnt,
                                    input logic [KIND_W-1:0] k0, input logic [KIND_W-1:0] k1,
                                    input logic [KIND_W-1:0] k2, input logic [VAL_W-1:0] v0,
                                    input logic [VAL_W-1:0] v1, input logic [VAL_W-1:0] v2,
                                    input bit known, input bit hit,
                                    input logic [OP_W-1:0] word);
        stim_t r;
        r.it.mnemonic = mn;
        r.it.count    = cnt[CNT_W-1:0];
        r.it.kd[0]    = k0;
        r.it.kd[1]    = k1;
        r.it.kd[2]    = k2;
        r.it.val[0]   = v0;
        r.it.val[1]   = v1;
        r.it.val[2]   = v2;
        r.known       = known;
        r.hit         = hit;
        r.word        = word;
        directed.push_back(r);
    endfunction

    // first format in table order that agrees on mnemonic, count and used kinds
    function automatic encoding_t encode_instruction(input instr_t it);
        encoding_t   e;
        logic [31:0] acc;
        bit          ok;
        e = '0;
        foreach (formats[i])
        begin
            ok = !e.hit && formats[i].mn == it.mnemonic && formats[i].cnt == it.count;
            for (int j = 0; j < NUM_OPS; j++)
                if (j < it.count && formats[i].kd[j] != it.kd[j])
                    ok = 1'b0;
            if (ok)
            begin
                acc = {16'd0, formats[i].base};
                for (int j = 0; j < NUM_OPS; j++)
                    if (j < it.count)
                        acc |= ({20'd0, it.val[j]} << formats[i].sh[j])
                               & {16'd0, formats[i].mk[j]};
                e.hit  = 1'b1;
                e.word = acc[OP_W-1:0];
            end
        end
        return e;
    endfunction

    task automatic send(input stim_t r);
        while (!no_idle && $urandom_range(99) < 8)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        offer    <= r;
        in_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!(in_valid && in_ready));
        @(negedge clk);
    endtask

    initial
    begin
        add_fmt(MN_CLS,  16'h00E0, 0, KD_V,  KD_V,  KD_V, 16'h0000, 16'h0000, 16'h0000, 0, 0, 0);
        add_fmt(MN_RET,  16'h00EE, 0, KD_V,  KD_V,  KD_V, 16'h0000, 16'h0000, 16'h0000, 0, 0, 0);
        add_fmt(MN_CALL, 16'h2000, 1, KD_N,  KD_V,  KD_V, 16'h0FFF, 16'h0000, 16'h0000, 0, 0, 0);
        add_fmt(MN_SE,   16'h3000, 2, KD_V,  KD_N,  KD_V, 16'h0F00, 16'h00FF, 16'h0000, 8, 0, 0);
        add_fmt(MN_SNE,  16'h4000, 2, KD_V,  KD_N,  KD_V, 16'h0F00, 16'h00FF, 16'h0000, 8, 0, 0);
        add_fmt(MN_SE,   16'h5000, 2, KD_V,  KD_V,  KD_V, 16'h0F00, 16'h00F0, 16'h0000, 8, 4, 0);
        add_fmt(MN_LD,   16'h6000, 2, KD_V,  KD_N,  KD_V, 16'h0F00, 16'h00FF, 16'h0000, 8, 0, 0);
        add_fmt(MN_ADD,  16'h7000, 2, KD_V,  KD_N,  KD_V, 16'h0F00, 16'h00FF, 16'h0000, 8, 0, 0);
        add_fmt(MN_LD,   16'h8000, 2, KD_V,  KD_V,  KD_V, 16'h0F00, 16'h00F0, 16'h0000, 8, 4, 0);
        add_fmt(MN_OR,   16'h8001, 2, KD_V,  KD_V,  KD_V, 16'h0F00, 16'h00F0, 16'h0000, 8, 4, 0);
        add_fmt(MN_AND,  16'h8002, 2, KD_V,  KD_V,  KD_V, 16'h0F00, 16'h00F0, 16'h0000, 8, 4, 0);
        add_fmt(MN_XOR,  16'h8003, 2, KD_V,  KD_V,  KD_V, 16'h0F00, 16'h00F0, 16'h0000, 8, 4, 0);
        add_fmt(MN_ADD,  16'h8004, 2, KD_V,  KD_V,  KD_V, 16'h0F00, 16'h00F0, 16'h0000, 8, 4, 0);
        add_fmt(MN_SUB,  16'h8005, 2, KD_V,  KD_V,  KD_V, 16'h0F00, 16'h00F0, 16'h0000, 8, 4, 0);
        add_fmt(MN_SHR,  16'h8006, 1, KD_V,  KD_V,  KD_V, 16'h0F00, 16'h0000, 16'h0000, 8, 0, 0);
        add_fmt(MN_SUBN, 16'h8007, 2, KD_V,  KD_V,  KD_V, 16'h0F00, 16'h00F0, 16'h0000, 8, 4, 0);
        add_fmt(MN_SHL,  16'h800E, 1, KD_V,  KD_V,  KD_V, 16'h0F00, 16'h0000, 16'h0000, 8, 0, 0);
        add_fmt(MN_SNE,  16'h9000, 2, KD_V,  KD_V,  KD_V, 16'h0F00, 16'h00F0, 16'h0000, 8, 4, 0);
        add_fmt(MN_LD,   16'hA000, 2, KD_I,  KD_N,  KD_V, 16'h0000, 16'h0FFF, 16'h0000, 0, 0, 0);
        add_fmt(MN_JP,   16'hB000, 2, KD_V,  KD_N,  KD_V, 16'h0000, 16'h0FFF, 16'h0000, 0, 0, 0);
        add_fmt(MN_RND,  16'hC000, 2, KD_V,  KD_N,  KD_V, 16'h0F00, 16'h00FF, 16'h0000, 8, 0, 0);
        add_fmt(MN_DRW,  16'hD000, 3, KD_V,  KD_V,  KD_N, 16'h0F00, 16'h00F0, 16'h000F, 8, 4, 0);
        add_fmt(MN_SKP,  16'hE09E, 1, KD_V,  KD_V,  KD_V, 16'h0F00, 16'h0000, 16'h0000, 8, 0, 0);
        add_fmt(MN_SKNP, 16'hE0A1, 1, KD_V,  KD_V,  KD_V, 16'h0F00, 16'h0000, 16'h0000, 8, 0, 0);
        add_fmt(MN_LD,   16'hF007, 2, KD_V,  KD_DT, KD_V, 16'h0F00, 16'h0000, 16'h0000, 8, 0, 0);
        add_fmt(MN_LD,   16'hF00A, 2, KD_V,  KD_K,  KD_V, 16'h0F00, 16'h0000, 16'h0000, 8, 0, 0);
        add_fmt(MN_LD,   16'hF015, 2, KD_DT, KD_V,  KD_V, 16'h0000, 16'h0F00, 16'h0000, 0, 8, 0);
        add_fmt(MN_LD,   16'hF018, 2, KD_ST, KD_V,  KD_V, 16'h0000, 16'h0F00, 16'h0000, 0, 8, 0);
        add_fmt(MN_ADD,  16'hF01E, 2, KD_I,  KD_V,  KD_V, 16'h0000, 16'h0F00, 16'h0000, 0, 8, 0);
        add_fmt(MN_LD,   16'hF029, 2, KD_F,  KD_V,  KD_V, 16'h0000, 16'h0F00, 16'h0000, 0, 8, 0);
        add_fmt(MN_LD,   16'hF033, 2, KD_B,  KD_V,  KD_V, 16'h0000, 16'h0F00, 16'h0000, 0, 8, 0);
        add_fmt(MN_LD,   16'hF055, 2, KD_IP, KD_V,  KD_V, 16'h0000, 16'h0F00, 16'h0000, 0, 8, 0);
        add_fmt(MN_LD,   16'hF065, 2, KD_V,  KD_IP, KD_V, 16'h0F00, 16'h0000, 16'h0000, 8, 0, 0);

        // directed rows: typed result where it is obvious, matcher otherwise
        add_row(MN_CLS,   0, KD_V, KD_V, KD_V, 12'h000, 12'h000, 12'h000, 1, 1, 16'h00E0);
        // operands past the count are don't-care
        add_row(MN_RET,   0, KD_BOGUS, KD_BOGUS, KD_BOGUS, 12'hFFF, 12'hFFF, 12'hFFF,
                1, 1, 16'h00EE);
        add_row(MN_CALL,  1, KD_N, KD_V, KD_V, 12'hFFF, 12'h000, 12'h000, 1, 1, 16'h2FFF);
        // register of JP V0, addr is not encoded
        add_row(MN_JP,    2, KD_V, KD_N, KD_V, 12'h007, 12'hFFF, 12'h000, 1, 1, 16'hBFFF);
        // there is no plain JP addr form
        add_row(MN_JP,    1, KD_N, KD_V, KD_V, 12'h200, 12'h000, 12'h000, 1, 0, 16'h0000);
        // oversized values are cut to their field
        add_row(MN_SE,    2, KD_V, KD_N, KD_V, 12'hFFF, 12'hFFF, 12'h000, 1, 1, 16'h3FFF);
        add_row(MN_DRW,   3, KD_V, KD_V, KD_N, 12'hFFF, 12'hFFF, 12'hFFF, 1, 1, 16'hDFFF);
        add_row(MN_DRW,   3, KD_V, KD_V, KD_N, 12'h000, 12'h000, 12'h000, 1, 1, 16'hD000);
        add_row(MN_BOGUS, 0, KD_V, KD_V, KD_V, 12'h000, 12'h000, 12'h000, 1, 0, 16'h0000);
        add_row(MN_LD,    2, KD_V, KD_BOGUS, KD_V, 12'h003, 12'h000, 12'h000, 1, 0, 16'h0000);
        add_row(MN_SNE,   2, KD_V, KD_V, KD_V, 12'h005, 12'h00A, 12'h000, 0, 0, 16'h0000);
        add_row(MN_LD,    2, KD_V, KD_N, KD_V, 12'h002, 12'h0AB, 12'h000, 0, 0, 16'h0000);
        add_row(MN_LD,    2, KD_V, KD_V, KD_V, 12'h001, 12'h002, 12'h000, 0, 0, 16'h0000);
        add_row(MN_ADD,   2, KD_I, KD_V, KD_V, 12'h000, 12'h00C, 12'h000, 0, 0, 16'h0000);
        add_row(MN_OR,    2, KD_V, KD_V, KD_V, 12'h001, 12'h002, 12'h000, 0, 0, 16'h0000);
        add_row(MN_AND,   2, KD_V, KD_V, KD_V, 12'h003, 12'h004, 12'h000, 0, 0, 16'h0000);
        add_row(MN_SUB,   2, KD_V, KD_V, KD_V, 12'h005, 12'h006, 12'h000, 0, 0, 16'h0000);
        add_row(MN_SHR,   1, KD_V, KD_V, KD_V, 12'h007, 12'h000, 12'h000, 0, 0, 16'h0000);
        add_row(MN_SUBN,  2, KD_V, KD_V, KD_V, 12'h008, 12'h009, 12'h000, 0, 0, 16'h0000);
        add_row(MN_SHL,   1, KD_V, KD_V, KD_V, 12'h00A, 12'h000, 12'h000, 0, 0, 16'h0000);
        add_row(MN_RND,   2, KD_V, KD_N, KD_V, 12'h00B, 12'h07F, 12'h000, 0, 0, 16'h0000);
        add_row(MN_SKP,   1, KD_V, KD_V, KD_V, 12'h00C, 12'h000, 12'h000, 0, 0, 16'h0000);
        add_row(MN_SKNP,  1, KD_V, KD_V, KD_V, 12'h00D, 12'h000, 12'h000, 0, 0, 16'h0000);
        add_row(MN_XOR,   2, KD_V, KD_V, KD_V, 12'h00E, 12'h00F, 12'h000, 0, 0, 16'h0000);
        add_row(MN_LD,    2, KD_F, KD_V, KD_V, 12'h000, 12'h009, 12'h000, 0, 0, 16'h0000);
    end

    // sender
    initial
    begin
        stim_t r;
        fmt_t  f;
        int    pick;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        offer    = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        foreach (directed[i])
            send(directed[i]);
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            no_idle = (n >= 400 && n < 700);
            r       = '0;
            pick    = $urandom_range(99);
            f       = formats[$urandom_range(formats.size() - 1)];
            if (pick < 90)
            begin
                r.it.mnemonic = f.mn;
                r.it.count    = f.cnt;
                for (int j = 0; j < NUM_OPS; j++)
                    r.it.kd[j] = (j < f.cnt) ? f.kd[j] : KIND_W'($urandom_range(15));
                // break a legal form: one wrong kind, or a wrong count
                if (pick >= 85)
                    r.it.count = CNT_W'($urandom_range(3));
                else if (pick >= 75)
                    r.it.kd[$urandom_range(NUM_OPS - 1)] = KIND_W'($urandom_range(15));
            end
            else
            begin
                r.it.mnemonic = MN_W'($urandom_range(31));
                r.it.count    = CNT_W'($urandom_range(3));
                for (int j = 0; j < NUM_OPS; j++)
                    r.it.kd[j] = KIND_W'($urandom_range(15));
            end
            for (int j = 0; j < NUM_OPS; j++)
                case ($urandom_range(7))
                    0:       r.it.val[j] = 12'h000;
                    1:       r.it.val[j] = 12'hFFF;
                    2:       r.it.val[j] = VAL_W'($urandom_range(15));
                    default: r.it.val[j] = VAL_W'($urandom_range(4095));
                endcase
            send(r);
        end
        no_idle = 1'b0;
        in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        $display("Sent %0d instructions (%0d directed, %0d random), all formats and garbage.",
                 n_accepted, directed.size(), RANDOM_ITEMS);
        $display("Results seen: %0d encoded, %0d rejected, %0d mismatches.",
                 n_encoded, n_rejected, n_errors);
        if (n_errors == 0 && expected_words.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // receiver, with one long hold-off once the run is under way
    initial
    begin
        int hold_left;
        bit held;
        hold_left = 0;
        held      = 1'b0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (!held && n_accepted >= HOLD_AT)
            begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= no_idle || $urandom_range(99) >= 8;
        end
    end

    // predict on input accept, check on output accept
    always @(posedge clk)
    begin
        encoding_t want;
        if (rst_n && in_valid && in_ready)
        begin
            n_accepted++;
            if (offer.known)
            begin
                want.hit  = offer.hit;
                want.word = offer.word;
            end
            else
                want = encode_instruction(offer.it);
            expected_words.push_back(want);
        end
        if (rst_n && out_valid && out_ready)
        begin
            if (matched)
                n_encoded++;
            else
                n_rejected++;
            if (expected_words.size() == 0)
            begin
                $display("%0t: result with no instruction pending: matched %b opcode %h",
                         $time, matched, opcode);
                n_errors++;
            end
            else
            begin
                want = expected_words.pop_front();
                if (matched !== want.hit)
                begin
                    $display("%0t: matched expected %b got %b", $time, want.hit, matched);
                    n_errors++;
                end
                if (opcode !== want.word)
                begin
                    $display("%0t: opcode expected %h got %h", $time, want.word, opcode);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d results pending",
                     $time, cycles, expected_words.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/c8enc_pkg.sv
rtl/core/c8enc_match.sv
rtl/core/chip8_instruction_encoder.sv
tb/chip8_instruction_encoder_tb.sv
